>>> rtl/ttps_pkg.sv
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared sizes, codes and beat types of the transposition table probe store.
// ----------------------------------------------------------------------------
package ttps_pkg;

    localparam int ENTRIES   = 4096;
    localparam int MOVE_BITS = 16;
    localparam int IDX_BITS  = $clog2(ENTRIES);
    localparam int NUM_CNT   = 6;

    // commands
    localparam logic [1:0] CMD_PROBE      = 2'd0;
    localparam logic [1:0] CMD_STORE      = 2'd1;
    localparam logic [1:0] CMD_CLEAR_KEYS = 2'd2;
    localparam logic [1:0] CMD_CLEAR_CNT  = 2'd3;

    // node kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_EXACT = 2'd1;
    localparam logic [1:0] KIND_LOWER = 2'd2;
    localparam logic [1:0] KIND_UPPER = 2'd3;

    // counter slots
    localparam int CNT_HIT        = 0;
    localparam int CNT_MISS       = 1;
    localparam int CNT_SCORE_HIT  = 2;
    localparam int CNT_SCORE_MISS = 3;
    localparam int CNT_MOVE_HIT   = 4;
    localparam int CNT_MOVE_MISS  = 5;

    typedef struct packed {
        logic [1:0]         command;
        logic [63:0]        key;
        logic signed [15:0] score;
        logic [15:0]        move;
        logic signed [7:0]  depth;
        logic [1:0]         node_kind;
        logic               score_flag;
        logic               move_flag;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } in_beat_t;

    typedef struct packed {
        logic               lookup_hit;
        logic               score_valid;
        logic signed [15:0] score_value;
        logic               move_valid;
        logic [15:0]        move_value;
        logic [31:0]        hit_count;
        logic [31:0]        miss_count;
        logic [31:0]        score_hit_count;
        logic [31:0]        score_miss_count;
        logic [31:0]        move_hit_count;
        logic [31:0]        move_miss_count;
    } out_beat_t;

    // one table slot apart from its key
    typedef struct packed {
        logic signed [15:0]     score;
        logic [MOVE_BITS-1:0]   move;
        logic signed [7:0]      depth;
        logic                   move_flag;
        logic                   score_flag;
        logic [1:0]             kind;
    } entry_t;

endpackage

>>> rtl/transposition_table_probe_store.sv
// ----------------------------------------------------------------------------
// transposition_table_probe_store
// Direct-mapped search-result table with probe, store, clear and statistics.
// ----------------------------------------------------------------------------
// One beat in, one beat out, one command at a time. For probe, store and
// clear counters the accept cycle issues the synchronous read of the key and
// entry memories; the evaluation state then compares and updates the counters
// into the output register once that register is free. Clear keys sweeps the
// key memory one slot per cycle before its result. After reset the block zeroes
// both memories in one pass and holds s_ready low until it is done. A new beat
// is taken while the previous result still waits.
module transposition_table_probe_store import ttps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    typedef enum logic [1:0] {ST_INIT, ST_IDLE, ST_EVAL, ST_CLEAR} state_t;

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   sweep_reg, sweep_next;
    in_beat_t              req_reg, req_next;
    logic                  m_valid_reg, m_valid_next;
    out_beat_t             m_data_reg, m_data_next;
    logic [31:0]           cnt_reg [NUM_CNT];
    logic [31:0]           cnt_next [NUM_CNT];

    logic [63:0]           key_mem [ENTRIES];
    entry_t                data_mem [ENTRIES];
    logic [63:0]           key_rd_reg;
    entry_t                data_rd_reg;

    logic                  accept;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  key_we, data_we;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [63:0]           key_wdata;
    entry_t                data_wdata;
    logic                  sweep_last;
    logic                  commit;

    logic                  hit, score_ok, sv, mv;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign sweep_last = (sweep_reg == IDX_BITS'(ENTRIES - 1));
    assign commit     = (state_reg == ST_EVAL) && (!m_valid_reg || m_ready);

    // the read address stays on the pending slot while the result stalls
    assign rd_addr = (state_reg == ST_IDLE) ? s_data.key[IDX_BITS-1:0]
                                            : req_reg.key[IDX_BITS-1:0];

    always_comb begin
        key_we     = (state_reg == ST_INIT) || (state_reg == ST_CLEAR) ||
                     (accept && (s_data.command == CMD_STORE));
        data_we    = (state_reg == ST_INIT) ||
                     (accept && (s_data.command == CMD_STORE));
        wr_addr    = accept ? s_data.key[IDX_BITS-1:0] : sweep_reg;
        key_wdata  = accept ? s_data.key : 64'd0;
        data_wdata = '0;
        if (accept) begin
            data_wdata.score      = s_data.score;
            data_wdata.move       = MOVE_BITS'(s_data.move);
            data_wdata.depth      = s_data.depth;
            data_wdata.move_flag  = s_data.move_flag;
            data_wdata.score_flag = s_data.score_flag;
            data_wdata.kind       = s_data.node_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= key_wdata;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (data_we) begin
            data_mem[wr_addr] <= data_wdata;
        end
        data_rd_reg <= data_mem[rd_addr];
    end

    // probe evaluation on the read data
    always_comb begin
        hit = (key_rd_reg == req_reg.key);
        case (data_rd_reg.kind)
            KIND_EXACT: score_ok = 1'b1;
            KIND_LOWER: score_ok = ($signed(data_rd_reg.score) >= $signed(req_reg.beta));
            KIND_UPPER: score_ok = ($signed(data_rd_reg.score) <= $signed(req_reg.alpha));
            default:    score_ok = 1'b0;
        endcase
        sv = hit && data_rd_reg.score_flag &&
             ($signed(data_rd_reg.depth) >= $signed(req_reg.depth)) && score_ok;
        mv = hit && data_rd_reg.move_flag;
    end

    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        req_next     = req_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        for (int i = 0; i < NUM_CNT; i++) begin
            cnt_next[i] = cnt_reg[i];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    req_next   = s_data;
                    sweep_next = '0;
                    state_next = (s_data.command == CMD_CLEAR_KEYS) ? ST_CLEAR : ST_EVAL;
                end
            end
            ST_CLEAR: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (commit) begin
                    m_data_next = '0;
                    case (req_reg.command)
                        CMD_PROBE: begin
                            if (hit) begin
                                cnt_next[CNT_HIT] = cnt_reg[CNT_HIT] + 32'd1;
                                if (sv) begin
                                    cnt_next[CNT_SCORE_HIT] = cnt_reg[CNT_SCORE_HIT] + 32'd1;
                                end else begin
                                    cnt_next[CNT_SCORE_MISS] = cnt_reg[CNT_SCORE_MISS] + 32'd1;
                                end
                                if (mv) begin
                                    cnt_next[CNT_MOVE_HIT] = cnt_reg[CNT_MOVE_HIT] + 32'd1;
                                end else begin
                                    cnt_next[CNT_MOVE_MISS] = cnt_reg[CNT_MOVE_MISS] + 32'd1;
                                end
                            end else begin
                                cnt_next[CNT_MISS] = cnt_reg[CNT_MISS] + 32'd1;
                            end
                            m_data_next.lookup_hit  = hit;
                            m_data_next.score_valid = sv;
                            m_data_next.score_value = sv ? data_rd_reg.score : 16'sd0;
                            m_data_next.move_valid  = mv;
                            m_data_next.move_value  = mv ? 16'(data_rd_reg.move) : 16'd0;
                        end
                        CMD_CLEAR_CNT: begin
                            for (int i = 0; i < NUM_CNT; i++) begin
                                cnt_next[i] = 32'd0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    m_data_next.hit_count        = cnt_next[CNT_HIT];
                    m_data_next.miss_count       = cnt_next[CNT_MISS];
                    m_data_next.score_hit_count  = cnt_next[CNT_SCORE_HIT];
                    m_data_next.score_miss_count = cnt_next[CNT_SCORE_MISS];
                    m_data_next.move_hit_count   = cnt_next[CNT_MOVE_HIT];
                    m_data_next.move_miss_count  = cnt_next[CNT_MOVE_MISS];
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CNT; i++) begin
                cnt_reg[i] <= 32'd0;
            end
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            m_valid_reg <= m_valid_next;
            for (int i = 0; i < NUM_CNT; i++) begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
        req_reg    <= req_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
